/* design/qbli_pkg.sv */
// Shared word types and a constant for the quadratic Bezier / axis line intersector.
package qbli_pkg;

   localparam int unsigned TONE = 65536;

   typedef struct packed {
      logic               vertical;
      logic signed [31:0] line_pos;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] ctrl_x;
      logic signed [31:0] ctrl_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         hit_count;
      logic signed [31:0] first_crossing;
      logic signed [31:0] second_crossing;
   } rsp_word_type;

endpackage

/* design/quad_bezier_line_intersect.sv */
// Pipelined crossing finder for a quadratic Bezier curve against an axis-aligned line.
//
//   channel | ports                        | direction
//   request | req_valid req_stall req_data | curve and line in
//   response| rsp_valid rsp_stall rsp_data | hit count and crossings out
//
// One curve enters per cycle while the response is not stalled.
// The pipeline depth comes from the digit-by-digit square root (35 stages) and the
// quotient for the curve parameter (17 stages), with setup and blend stages around them.
// Reset clears every stage's valid bit. A stalled response freezes the whole pipeline,
// and req_stall follows it in the same cycle.
module quad_bezier_line_intersect (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  qbli_pkg::req_word_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output qbli_pkg::rsp_word_type  rsp_data
);

   localparam int SQ_STEPS = 35;
   localparam int DV_STEPS = 17;

   typedef struct packed {
      logic               lin;
      logic               ok;
      logic signed [33:0] a;
      logic signed [32:0] d;
      logic signed [34:0] lin_n;
      logic signed [33:0] lin_d;
      logic signed [31:0] p0;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } ctx_type;

   typedef struct packed {
      logic               valid;
      ctx_type            ctx;
      logic signed [32:0] e;
   } s1_type;

   typedef struct packed {
      logic        valid;
      ctx_type     ctx;
      logic [63:0] dd;
      logic [63:0] ae_lo;
      logic [33:0] ae_hi;
      logic        neg;
   } s2_type;

   typedef struct packed {
      logic        valid;
      ctx_type     ctx;
      logic [63:0] dd;
      logic [65:0] ae;
      logic        neg;
   } s3_type;

   typedef struct packed {
      logic        valid;
      ctx_type     ctx;
      logic [37:0] rem;
      logic [34:0] root;
      logic [69:0] val;
   } sq_type;

   typedef struct packed {
      logic signed [31:0] p0;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } pts_type;

   typedef struct packed {
      logic               good;
      logic signed [35:0] n;
      logic signed [35:0] den;
   } lane_type;

   typedef struct packed {
      logic     valid;
      pts_type  pts;
      lane_type l0;
      lane_type l1;
   } rs_type;

   typedef struct packed {
      logic        good;
      logic [33:0] rem;
      logic [33:0] den;
      logic [16:0] low;
      logic [16:0] q;
   } dlane_type;

   typedef struct packed {
      logic      valid;
      pts_type   pts;
      dlane_type l0;
      dlane_type l1;
   } dv_type;

   typedef struct packed {
      logic        good;
      logic [32:0] uu;
      logic [32:0] tu;
      logic [32:0] tt;
   } wlane_type;

   typedef struct packed {
      logic      valid;
      pts_type   pts;
      wlane_type l0;
      wlane_type l1;
   } pa_type;

   typedef struct packed {
      logic               good;
      logic signed [65:0] m0;
      logic signed [65:0] m1;
      logic signed [65:0] m2;
   } mlane_type;

   typedef struct packed {
      logic      valid;
      mlane_type l0;
      mlane_type l1;
   } pb_type;

   typedef struct packed {
      logic                  valid;
      qbli_pkg::rsp_word_type word;
   } pc_type;

   function automatic sq_type sq_step(input sq_type x);
      sq_type      y;
      logic [37:0] rem2;
      logic [37:0] trial;
      y     = x;
      rem2  = {x.rem[35:0], x.val[69:68]};
      trial = {1'b0, x.root, 2'b01};
      y.val = {x.val[67:0], 2'b00};
      if (rem2 >= trial) begin
         y.rem  = rem2 - trial;
         y.root = {x.root[33:0], 1'b1};
      end else begin
         y.rem  = rem2;
         y.root = {x.root[33:0], 1'b0};
      end
      return y;
   endfunction

   function automatic dlane_type dv_step(input dlane_type x);
      dlane_type   y;
      logic [34:0] r2;
      y     = x;
      r2    = {x.rem, x.low[16]};
      y.low = {x.low[15:0], 1'b0};
      if (r2 >= {1'b0, x.den}) begin
         y.rem = 34'(r2 - {1'b0, x.den});
         y.q   = {x.q[15:0], 1'b1};
      end else begin
         y.rem = r2[33:0];
         y.q   = {x.q[15:0], 1'b0};
      end
      return y;
   endfunction

   function automatic lane_type lane_norm(input lane_type x);
      lane_type y;
      y = x;
      if (x.den[35]) begin
         y.n   = -x.n;
         y.den = -x.den;
      end
      return y;
   endfunction

   function automatic dlane_type lane_init(input lane_type x);
      dlane_type   y;
      logic [50:0] num;
      num    = {1'b0, x.n[33:0], 16'b0} + {18'b0, x.den[33:1]};
      y.good = x.good && (x.den != '0) && !x.n[35] && (x.n <= x.den);
      y.rem  = num[50:17];
      y.low  = num[16:0];
      y.den  = x.den[33:0];
      y.q    = '0;
      return y;
   endfunction

   function automatic wlane_type lane_weights(input dlane_type x);
      wlane_type   y;
      logic [16:0] u;
      logic [33:0] uu;
      logic [33:0] tu;
      logic [33:0] tt;
      u      = 17'(qbli_pkg::TONE) - x.q;
      uu     = u * u;
      tu     = x.q * u;
      tt     = x.q * x.q;
      y.good = x.good;
      y.uu   = uu[32:0];
      y.tu   = {tu[31:0], 1'b0};
      y.tt   = tt[32:0];
      return y;
   endfunction

   function automatic mlane_type lane_mul(input wlane_type x, input pts_type p);
      mlane_type y;
      y.good = x.good;
      y.m0   = $signed({1'b0, x.uu}) * p.p0;
      y.m1   = $signed({1'b0, x.tu}) * p.p1;
      y.m2   = $signed({1'b0, x.tt}) * p.p2;
      return y;
   endfunction

   function automatic logic signed [31:0] lane_sum(input mlane_type x);
      logic signed [67:0] s;
      s = 68'(x.m0) + 68'(x.m1) + 68'(x.m2) + 68'sd2147483648;
      return s[63:32];
   endfunction

   logic     adv;
   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   sq_type   sq_ff [0:SQ_STEPS];
   sq_type   sq_in [0:SQ_STEPS];
   rs_type   rs_ff, rs_in;
   rs_type   nm_ff, nm_in;
   dv_type   dv_ff [0:DV_STEPS];
   dv_type   dv_in [0:DV_STEPS];
   pa_type   pa_ff, pa_in;
   pb_type   pb_ff, pb_in;
   pc_type   pc_ff, pc_in;

   // advance everything unless the finished word is held
   assign adv       = !(pc_ff.valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = pc_ff.valid;
   assign rsp_data  = pc_ff.word;

   always_comb begin
      logic signed [31:0] ca, cb, cc, cy;
      logic [33:0]        mag_a;
      logic [32:0]        mag_d, mag_e;
      logic [66:0]        diff;
      logic signed [35:0] dx;
      cy = req_data.line_pos;
      ca = req_data.vertical ? req_data.start_x : req_data.start_y;
      cb = req_data.vertical ? req_data.ctrl_x  : req_data.ctrl_y;
      cc = req_data.vertical ? req_data.end_x   : req_data.end_y;
      s1_in.valid     = req_valid;
      s1_in.ctx.p0    = req_data.vertical ? req_data.start_y : req_data.start_x;
      s1_in.ctx.p1    = req_data.vertical ? req_data.ctrl_y  : req_data.ctrl_x;
      s1_in.ctx.p2    = req_data.vertical ? req_data.end_y   : req_data.end_x;
      s1_in.ctx.a     = 34'(ca) - (34'(cb) <<< 1) + 34'(cc);
      s1_in.ctx.d     = 33'(ca) - 33'(cb);
      s1_in.e         = 33'(ca) - 33'(cy);
      s1_in.ctx.lin_n = (35'(cb) <<< 1) - 35'(cc) - 35'(cy);
      s1_in.ctx.lin_d = (34'(cb) - 34'(cc)) <<< 1;
      s1_in.ctx.lin   = 1'b0;
      s1_in.ctx.ok    = 1'b0;

      mag_a = s1_ff.ctx.a[33] ? 34'(-s1_ff.ctx.a) : 34'(s1_ff.ctx.a);
      mag_d = s1_ff.ctx.d[32] ? 33'(-s1_ff.ctx.d) : 33'(s1_ff.ctx.d);
      mag_e = s1_ff.e[32]     ? 33'(-s1_ff.e)     : 33'(s1_ff.e);
      s2_in.valid   = s1_ff.valid;
      s2_in.ctx     = s1_ff.ctx;
      s2_in.ctx.lin = (s1_ff.ctx.a == '0);
      s2_in.dd      = mag_d[31:0] * mag_d[31:0];
      s2_in.ae_lo   = mag_a[31:0] * mag_e[31:0];
      s2_in.ae_hi   = mag_a[33:32] * mag_e[31:0];
      s2_in.neg     = s1_ff.ctx.a[33] ^ s1_ff.e[32];

      s3_in.valid = s2_ff.valid;
      s3_in.ctx   = s2_ff.ctx;
      s3_in.dd    = s2_ff.dd;
      s3_in.ae    = {2'b0, s2_ff.ae_lo} + {s2_ff.ae_hi, 32'b0};
      s3_in.neg   = s2_ff.neg;

      // discriminant, then seed the square root
      diff = {3'b0, s3_ff.dd} - {1'b0, s3_ff.ae};
      sq_in[0].valid = s3_ff.valid;
      sq_in[0].ctx   = s3_ff.ctx;
      sq_in[0].rem   = '0;
      sq_in[0].root  = '0;
      if (s3_ff.neg) begin
         sq_in[0].ctx.ok = 1'b1;
         sq_in[0].val    = {2'b0, {4'b0, s3_ff.dd} + {2'b0, s3_ff.ae}};
      end else begin
         sq_in[0].ctx.ok = !diff[66];
         sq_in[0].val    = {3'b0, diff};
      end
      for (int k = 1; k <= SQ_STEPS; k++) begin
         sq_in[k] = sq_step(sq_ff[k-1]);
      end

      // form both candidate parameters as numerator over denominator
      dx = 36'(sq_ff[SQ_STEPS].ctx.d);
      rs_in.valid   = sq_ff[SQ_STEPS].valid;
      rs_in.pts.p0  = sq_ff[SQ_STEPS].ctx.p0;
      rs_in.pts.p1  = sq_ff[SQ_STEPS].ctx.p1;
      rs_in.pts.p2  = sq_ff[SQ_STEPS].ctx.p2;
      rs_in.l0.good = sq_ff[SQ_STEPS].ctx.lin | sq_ff[SQ_STEPS].ctx.ok;
      rs_in.l1.good = !sq_ff[SQ_STEPS].ctx.lin & sq_ff[SQ_STEPS].ctx.ok;
      rs_in.l0.n    = sq_ff[SQ_STEPS].ctx.lin ? 36'(sq_ff[SQ_STEPS].ctx.lin_n)
                    : dx + $signed({1'b0, sq_ff[SQ_STEPS].root});
      rs_in.l1.n    = dx - $signed({1'b0, sq_ff[SQ_STEPS].root});
      rs_in.l0.den  = sq_ff[SQ_STEPS].ctx.lin ? 36'(sq_ff[SQ_STEPS].ctx.lin_d)
                    : 36'(sq_ff[SQ_STEPS].ctx.a);
      rs_in.l1.den  = 36'(sq_ff[SQ_STEPS].ctx.a);

      nm_in       = rs_ff;
      nm_in.l0    = lane_norm(rs_ff.l0);
      nm_in.l1    = lane_norm(rs_ff.l1);

      dv_in[0].valid = nm_ff.valid;
      dv_in[0].pts   = nm_ff.pts;
      dv_in[0].l0    = lane_init(nm_ff.l0);
      dv_in[0].l1    = lane_init(nm_ff.l1);
      for (int k = 1; k <= DV_STEPS; k++) begin
         dv_in[k]    = dv_ff[k-1];
         dv_in[k].l0 = dv_step(dv_ff[k-1].l0);
         dv_in[k].l1 = dv_step(dv_ff[k-1].l1);
      end

      pa_in.valid = dv_ff[DV_STEPS].valid;
      pa_in.pts   = dv_ff[DV_STEPS].pts;
      pa_in.l0    = lane_weights(dv_ff[DV_STEPS].l0);
      pa_in.l1    = lane_weights(dv_ff[DV_STEPS].l1);

      pb_in.valid = pa_ff.valid;
      pb_in.l0    = lane_mul(pa_ff.l0, pa_ff.pts);
      pb_in.l1    = lane_mul(pa_ff.l1, pa_ff.pts);

      // pack hits in order, unused slots zero
      pc_in.valid               = pb_ff.valid;
      pc_in.word.hit_count      = 2'(pb_ff.l0.good) + 2'(pb_ff.l1.good);
      pc_in.word.second_crossing = '0;
      if (pb_ff.l0.good) begin
         pc_in.word.first_crossing = lane_sum(pb_ff.l0);
         if (pb_ff.l1.good) begin
            pc_in.word.second_crossing = lane_sum(pb_ff.l1);
         end
      end else if (pb_ff.l1.good) begin
         pc_in.word.first_crossing = lane_sum(pb_ff.l1);
      end else begin
         pc_in.word.first_crossing = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         sq_ff <= '{default: '0};
         rs_ff <= '0;
         nm_ff <= '0;
         dv_ff <= '{default: '0};
         pa_ff <= '0;
         pb_ff <= '0;
         pc_ff <= '0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         sq_ff <= sq_in;
         rs_ff <= rs_in;
         nm_ff <= nm_in;
         dv_ff <= dv_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
      end
   end

endmodule

/* sim/qbli_checker.sv */
// Watches both channels, predicts each crossing word and compares it with the block's output.
module qbli_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  qbli_pkg::req_word_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  qbli_pkg::rsp_word_type rsp_data,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   qbli_pkg::rsp_word_type crossing_queue[$];

   assign pending = crossing_queue.size();

   // t = n/d, rejected outside [0,1], rounded to Q1.16 half up
   function automatic bit param_in_range(longint n, longint d, output longint tq);
      tq = 0;
      if (d == 0) return 0;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n < 0 || n > d) return 0;
      tq = (n * qbli_pkg::TONE + d / 2) / d;
      return 1;
   endfunction

   function automatic logic signed [31:0] blend_at(longint tq, longint p0, longint p1,
                                                   longint p2);
      logic signed [65:0] t_w, u_w, sum;
      t_w = 66'(tq);
      u_w = 66'(longint'(qbli_pkg::TONE) - tq);
      sum = u_w * u_w * 66'(signed'(p0)) + 2 * t_w * u_w * 66'(signed'(p1))
          + t_w * t_w * 66'(signed'(p2));
      sum = (sum + 66'sd2147483648) >>> 32;
      return sum[31:0];
   endfunction

   function automatic qbli_pkg::rsp_word_type crossings_of(qbli_pkg::req_word_type w);
      longint A, B, C, P0, P1, P2, y, a, d, e, s, tq;
      logic signed [135:0] d_w, a_w, e_w, disc, c_w;
      qbli_pkg::rsp_word_type r;
      int n;
      n = 0;
      r = '0;
      y  = longint'(w.line_pos);
      A  = longint'(w.vertical ? w.start_x : w.start_y);
      B  = longint'(w.vertical ? w.ctrl_x  : w.ctrl_y);
      C  = longint'(w.vertical ? w.end_x   : w.end_y);
      P0 = longint'(w.vertical ? w.start_y : w.start_x);
      P1 = longint'(w.vertical ? w.ctrl_y  : w.ctrl_x);
      P2 = longint'(w.vertical ? w.end_y   : w.end_x);
      a = A - 2 * B + C;
      if (a == 0) begin
         if (param_in_range(2 * B - C - y, 2 * (B - C), tq)) begin
            r.first_crossing = blend_at(tq, P0, P1, P2);
            n = 1;
         end
      end else begin
         d = A - B;
         e = A - y;
         d_w = 136'(d);
         a_w = 136'(a);
         e_w = 136'(e);
         disc = d_w * d_w - a_w * e_w;
         if (disc >= 0) begin
            s = 0;
            for (int b = 34; b >= 0; b--) begin
               c_w = 136'(s | (longint'(1) << b));
               if (c_w * c_w <= disc) s = s | (longint'(1) << b);
            end
            if (param_in_range(d + s, a, tq)) begin
               r.first_crossing = blend_at(tq, P0, P1, P2);
               n = 1;
            end
            if (param_in_range(d - s, a, tq)) begin
               if (n == 0) r.first_crossing = blend_at(tq, P0, P1, P2);
               else r.second_crossing = blend_at(tq, P0, P1, P2);
               n++;
            end
         end
      end
      r.hit_count = 2'(n);
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      qbli_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) crossing_queue.push_back(crossings_of(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (crossing_queue.size() == 0) begin
               report("unexpected word", 32'(rsp_data.hit_count), 32'd0);
            end else begin
               want = crossing_queue.pop_front();
               if (rsp_data.hit_count != want.hit_count)
                  report("hit_count", 32'(rsp_data.hit_count), 32'(want.hit_count));
               if (rsp_data.first_crossing != want.first_crossing)
                  report("first_crossing", rsp_data.first_crossing, want.first_crossing);
               if (rsp_data.second_crossing != want.second_crossing)
                  report("second_crossing", rsp_data.second_crossing, want.second_crossing);
            end
         end
      end
   end

endmodule

/* sim/tb_top.sv */
// Testbench top: drives curves and line positions into the intersector and gives the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam logic signed [31:0] MOST = 32'h7fffffff;
   localparam logic signed [31:0] LEAST = 32'h80000000;
   localparam logic signed [31:0] ONE = 32'h00010000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   qbli_pkg::req_word_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   qbli_pkg::rsp_word_type rsp_data;
   int                     fail_count, pending;
   int                     idle_cycles = 0;
   int                     hold_left = 0;
   logic                   rsp_took = 1'b0;
   bit                     quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quad_bezier_line_intersect u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   qbli_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver: hold off a random number of cycles after each word taken, unless quiet
   always @(posedge clock) rsp_took <= rsp_valid && !rsp_stall;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_took && !quiet) hold_left <= $urandom_range(0, 7);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // entered and left at a falling edge
   task automatic send(qbli_pkg::req_word_type w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic qbli_pkg::req_word_type curve(bit v, logic [31:0] y, logic [31:0] ax,
         logic [31:0] ay, logic [31:0] bx, logic [31:0] by, logic [31:0] cx,
         logic [31:0] cy);
      qbli_pkg::req_word_type w;
      w = {v, y, ax, ay, bx, by, cx, cy};
      return w;
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return LEAST;
         1: return MOST;
         2: return 0;
         3: return 32'hffffffff;
         4: return 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic qbli_pkg::req_word_type random_curve();
      qbli_pkg::req_word_type w;
      int span;
      longint A, C;
      w.line_pos = $urandom;
      w.start_x = $urandom; w.start_y = $urandom;
      w.ctrl_x = $urandom;  w.ctrl_y = $urandom;
      w.end_x = $urandom;   w.end_y = $urandom;
      w.vertical = 1'($urandom_range(0, 1));
      span = 1 << $urandom_range(4, 22);
      case ($urandom_range(0, 9))
         0, 1: ;  // full-range noise
         2: begin
            w.line_pos = pick_extreme();
            w.start_x = pick_extreme(); w.start_y = pick_extreme();
            w.ctrl_x = pick_extreme();  w.ctrl_y = pick_extreme();
            w.end_x = pick_extreme();   w.end_y = pick_extreme();
         end
         3, 4: begin
            // straight along the normal: a is zero
            A = $signed($urandom_range(0, 2 * span)) - span;
            C = $signed($urandom_range(0, 2 * span)) - span;
            if ((A + C) % 2 != 0) C = C + 1;
            w.start_x = $signed($urandom_range(0, 2 * span)) - span;
            w.ctrl_x = $signed($urandom_range(0, 2 * span)) - span;
            w.end_x = $signed($urandom_range(0, 2 * span)) - span;
            w.start_y = 32'(A); w.ctrl_y = 32'((A + C) / 2); w.end_y = 32'(C);
            w.line_pos = $signed($urandom_range(0, 2 * span)) - span;
            if (w.vertical) begin
               {w.start_x, w.start_y} = {w.start_y, w.start_x};
               {w.ctrl_x, w.ctrl_y} = {w.ctrl_y, w.ctrl_x};
               {w.end_x, w.end_y} = {w.end_y, w.end_x};
            end
         end
         default: begin
            // small curve with the line through its span
            w.line_pos = $signed($urandom_range(0, 2 * span)) - span;
            w.start_x = $signed($urandom_range(0, 2 * span)) - span;
            w.start_y = $signed($urandom_range(0, 2 * span)) - span;
            w.ctrl_x = $signed($urandom_range(0, 4 * span)) - 2 * span;
            w.ctrl_y = $signed($urandom_range(0, 4 * span)) - 2 * span;
            w.end_x = $signed($urandom_range(0, 2 * span)) - span;
            w.end_y = $signed($urandom_range(0, 2 * span)) - span;
         end
      endcase
      return w;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // parabola with apex y=0.5 at t=0.5, the line through the apex; both orientations
      send(curve(1'b0, ONE / 2, 0, 0, ONE, ONE, 2 * ONE, 0));
      send(curve(1'b1, ONE / 2, 0, 0, ONE, ONE, 2 * ONE, 0));
      send(curve(1'b1, ONE / 2, 0, 0, ONE, ONE, 0, 2 * ONE));
      // tangent line: equal roots
      send(curve(1'b0, ONE / 2, 0, ONE, ONE, 0, 2 * ONE, ONE));
      // line misses: negative discriminant
      send(curve(1'b0, -ONE, 0, ONE, ONE, 0, 2 * ONE, ONE));
      // straight segment, and a degenerate one with no crossing
      send(curve(1'b0, ONE, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE));
      send(curve(1'b0, ONE, 0, ONE, ONE, ONE, 2 * ONE, ONE));
      send(curve(1'b1, 0, 0, 0, 0, 0, 0, 0));
      // endpoints exactly on the line
      send(curve(1'b0, 0, 5, 0, 7, ONE, 9, 0));
      send(curve(1'b0, 0, 5, 0, 7, 3 * ONE, 9, 2 * ONE));
      send(curve(1'b0, 2 * ONE, 5, 0, 7, 3 * ONE, 9, 2 * ONE));
      // extremes
      send(curve(1'b0, LEAST, LEAST, LEAST, MOST, MOST, LEAST, LEAST));
      send(curve(1'b1, MOST, MOST, MOST, LEAST, LEAST, MOST, MOST));
      send(curve(1'b0, 0, MOST, LEAST, LEAST, MOST, MOST, LEAST));
      send(curve(1'b1, 0, LEAST, MOST, MOST, LEAST, LEAST, MOST));
      send(curve(1'b0, MOST, LEAST, LEAST, LEAST, LEAST, MOST, MOST));
      send(curve(1'b1, LEAST, MOST, MOST, MOST, MOST, LEAST, LEAST));
      send(curve(1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, 32'hffffffff, 1));
      send(curve(1'b1, '1, '1, '1, '1, '1, '1, '1));

      for (int i = 0; i < 450; i++) begin
         if (i % 75 == 0) quiet = ($urandom_range(0, 2) == 0);
         send(random_curve());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

/* quad_bezier_line_intersect.f */
design/qbli_pkg.sv
design/quad_bezier_line_intersect.sv
sim/qbli_checker.sv
sim/tb_top.sv
